/* hw/rtl/pcet_pkg.sv */
// Shared types and constants of the pair collision event tracker.
`timescale 1ns / 1ps

package pcet_pkg;

   localparam int ID_BITS     = 6;
   localparam int TABLE_AW    = 2 * ID_BITS;
   localparam int TABLE_DEPTH = 1 << TABLE_AW;
   localparam int ENTRY_BITS  = 2;
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int EDGE_COUNT  = 4;

   // Bit positions of a pair table entry.
   localparam int PAIR_PRESENT_BIT   = 0;
   localparam int PAIR_COLLIDING_BIT = 1;

   typedef enum logic {
      CMD_CHECK = 1'b0,
      CMD_QUIT  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_STAY  = 2'd2,
      EV_EXIT  = 2'd3
   } event_code_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } back_state_type;

   typedef struct packed {
      cmd_type              command;
      logic [5:0]           left_id;
      logic [5:0]           right_id;
      logic                 other_is_line;
      logic signed [15:0]   box_x;
      logic signed [15:0]   box_y;
      logic [14:0]          box_w;
      logic [14:0]          box_h;
      logic signed [15:0]   other_a;
      logic signed [15:0]   other_b;
      logic signed [15:0]   other_c;
      logic signed [15:0]   other_d;
   } pcet_req_type;

   typedef struct packed {
      event_code_type event_res;
      logic           overlap;
   } pcet_rsp_type;

   // One classified request as it passes from the front to the back.
   typedef struct packed {
      cmd_type               command;
      logic [TABLE_AW-1:0]   pair_addr;
      logic                  pair_ok;
      logic                  overlap;
   } pcet_item_type;

   typedef struct packed {
      cmd_type               command;
      logic [TABLE_AW-1:0]   pair_addr;
      logic                  pair_ok;
      logic                  is_line;
   } pcet_meta_type;

endpackage

/* hw/rtl/pcet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pcet_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/pcet_queue.sv */
// Short queue of classified requests between the geometry front and the table back.
`timescale 1ns / 1ps

module pcet_queue import pcet_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pcet_item_type push_item,
   input  logic          pop,
   output logic          head_valid,
   output pcet_item_type head_item
);

   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   pcet_item_type       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNTW'(QUEUE_DEPTH)) || pop)
      else $error("request queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("request queue underflow");

endmodule

/* hw/rtl/pcet_front.sv */
// Front part: accepts requests, checks the ids and computes the shape overlap in a pipeline.
`timescale 1ns / 1ps

module pcet_front import pcet_pkg::*; #(
   parameter int ID_COUNT   = 64,
   parameter int COORD_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  pcet_req_type  req_payload,
   input  logic          clearing,
   input  logic          pop,
   output logic          push,
   output pcet_item_type push_item
);

   localparam int CW   = COORD_BITS;
   localparam int EW   = CW + 2;
   localparam int DW   = CW + 3;
   localparam int PW   = 2 * DW;
   localparam int NW   = PW + 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   function automatic logic in_span(input logic signed [NW-1:0] num,
                                    input logic signed [NW-1:0] den);
      logic r;
      if (den > 0) begin
         r = (num >= 0) && (num <= den);
      end else begin
         r = (num <= 0) && (num >= den);
      end
      return r;
   endfunction

   logic            accept;
   logic [CNTW-1:0] inflight_ff, inflight_in;

   logic signed [CW-1:0] bx_c, by_c, oa_c, ob_c, oc_c, od_c;
   logic [CW-2:0]        bw_c, bh_c;
   logic signed [EW-1:0] bwe, bhe, lx, rx, ty, yb, x1, y1, x2, y2;
   logic signed [EW-1:0] e_x3 [EDGE_COUNT];
   logic signed [EW-1:0] e_y3 [EDGE_COUNT];
   logic signed [EW-1:0] e_x4 [EDGE_COUNT];
   logic signed [EW-1:0] e_y4 [EDGE_COUNT];
   logic signed [DW-1:0] dxb, dyb;

   // Stage 1: differences.
   logic signed [DW-1:0] ex_ff [EDGE_COUNT], ex_in [EDGE_COUNT];
   logic signed [DW-1:0] ey_ff [EDGE_COUNT], ey_in [EDGE_COUNT];
   logic signed [DW-1:0] px_ff [EDGE_COUNT], px_in [EDGE_COUNT];
   logic signed [DW-1:0] py_ff [EDGE_COUNT], py_in [EDGE_COUNT];
   logic signed [DW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [DW-1:0] adx_ff, adx_in, ady_ff, ady_in;
   logic signed [DW-1:0] sumw_ff, sumw_in, sumh_ff, sumh_in;
   pcet_meta_type        m1_ff, m1_in;
   logic                 v1_ff;

   // Stage 2: products.
   logic signed [PW-1:0] pd1_ff [EDGE_COUNT], pd2_ff [EDGE_COUNT];
   logic signed [PW-1:0] pa1_ff [EDGE_COUNT], pa2_ff [EDGE_COUNT];
   logic signed [PW-1:0] pb1_ff [EDGE_COUNT], pb2_ff [EDGE_COUNT];
   logic                 box_hit2_ff, box_hit2_in;
   pcet_meta_type        m2_ff;
   logic                 v2_ff;

   // Stage 3: determinant and numerators.
   logic signed [NW-1:0] det_ff [EDGE_COUNT];
   logic signed [NW-1:0] na_ff [EDGE_COUNT];
   logic signed [NW-1:0] nb_ff [EDGE_COUNT];
   logic                 box_hit3_ff;
   pcet_meta_type        m3_ff;
   logic                 v3_ff;

   logic [EDGE_COUNT-1:0] seg_hit;

   // The credit count covers everything in the pipeline and the queue, so the
   // pipeline itself never has to stall.
   assign req_stall = clearing || (inflight_ff == CNTW'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      inflight_in = inflight_ff + CNTW'(accept) - CNTW'(pop);
   end

   // Coordinates are the low COORD_BITS bits of each field in two's complement.
   assign bx_c = CW'($unsigned(req_payload.box_x));
   assign by_c = CW'($unsigned(req_payload.box_y));
   assign oa_c = CW'($unsigned(req_payload.other_a));
   assign ob_c = CW'($unsigned(req_payload.other_b));
   assign oc_c = CW'($unsigned(req_payload.other_c));
   assign od_c = CW'($unsigned(req_payload.other_d));
   assign bw_c = (CW-1)'(req_payload.box_w);
   assign bh_c = (CW-1)'(req_payload.box_h);

   always_comb begin
      bwe = $signed(EW'(bw_c));
      bhe = $signed(EW'(bh_c));
      lx  = (EW'(bx_c) <<< 1) - bwe;
      rx  = (EW'(bx_c) <<< 1) + bwe;
      ty  = (EW'(by_c) <<< 1) - bhe;
      yb  = (EW'(by_c) <<< 1) + bhe;
      x1  = EW'(oa_c) <<< 1;
      y1  = EW'(ob_c) <<< 1;
      x2  = EW'(oc_c) <<< 1;
      y2  = EW'(od_c) <<< 1;

      // Left, right, top and bottom edges of the box.
      e_x3[0] = lx; e_y3[0] = yb; e_x4[0] = lx; e_y4[0] = ty;
      e_x3[1] = rx; e_y3[1] = yb; e_x4[1] = rx; e_y4[1] = ty;
      e_x3[2] = lx; e_y3[2] = ty; e_x4[2] = rx; e_y4[2] = ty;
      e_x3[3] = lx; e_y3[3] = yb; e_x4[3] = rx; e_y4[3] = yb;

      for (int k = 0; k < EDGE_COUNT; k++) begin
         ex_in[k] = DW'(e_x4[k]) - DW'(e_x3[k]);
         ey_in[k] = DW'(e_y4[k]) - DW'(e_y3[k]);
         px_in[k] = DW'(x1) - DW'(e_x3[k]);
         py_in[k] = DW'(y1) - DW'(e_y3[k]);
      end
      sx_in = DW'(x2) - DW'(x1);
      sy_in = DW'(y2) - DW'(y1);

      dxb     = (DW'(bx_c) - DW'(oa_c)) <<< 1;
      dyb     = (DW'(by_c) - DW'(ob_c)) <<< 1;
      adx_in  = (dxb < 0) ? -dxb : dxb;
      ady_in  = (dyb < 0) ? -dyb : dyb;
      sumw_in = $signed(DW'(bw_c)) + DW'(oc_c);
      sumh_in = $signed(DW'(bh_c)) + DW'(od_c);

      m1_in.command   = req_payload.command;
      m1_in.pair_addr = {req_payload.left_id, req_payload.right_id};
      m1_in.is_line   = req_payload.other_is_line;
      m1_in.pair_ok   = (req_payload.left_id != req_payload.right_id)
                        && (32'(req_payload.left_id) < 32'(ID_COUNT))
                        && (32'(req_payload.right_id) < 32'(ID_COUNT));
   end

   always_comb begin
      box_hit2_in = (adx_ff <= sumw_ff) && (ady_ff <= sumh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         v1_ff       <= accept;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff   <= m1_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      adx_ff  <= adx_in;
      ady_ff  <= ady_in;
      sumw_ff <= sumw_in;
      sumh_ff <= sumh_in;
      for (int k = 0; k < EDGE_COUNT; k++) begin
         ex_ff[k] <= ex_in[k];
         ey_ff[k] <= ey_in[k];
         px_ff[k] <= px_in[k];
         py_ff[k] <= py_in[k];
      end

      m2_ff       <= m1_ff;
      box_hit2_ff <= box_hit2_in;
      for (int k = 0; k < EDGE_COUNT; k++) begin
         pd1_ff[k] <= ey_ff[k] * sx_ff;
         pd2_ff[k] <= ex_ff[k] * sy_ff;
         pa1_ff[k] <= ex_ff[k] * py_ff[k];
         pa2_ff[k] <= ey_ff[k] * px_ff[k];
         pb1_ff[k] <= sx_ff * py_ff[k];
         pb2_ff[k] <= sy_ff * px_ff[k];
      end

      m3_ff       <= m2_ff;
      box_hit3_ff <= box_hit2_ff;
      for (int k = 0; k < EDGE_COUNT; k++) begin
         det_ff[k] <= NW'(pd1_ff[k]) - NW'(pd2_ff[k]);
         na_ff[k]  <= NW'(pa1_ff[k]) - NW'(pa2_ff[k]);
         nb_ff[k]  <= NW'(pb1_ff[k]) - NW'(pb2_ff[k]);
      end
   end

   // A parallel or degenerate edge has a zero determinant and never hits.
   always_comb begin
      for (int k = 0; k < EDGE_COUNT; k++) begin
         seg_hit[k] = (det_ff[k] != '0) && in_span(na_ff[k], det_ff[k])
                      && in_span(nb_ff[k], det_ff[k]);
      end
      push_item.command   = m3_ff.command;
      push_item.pair_addr = m3_ff.pair_addr;
      push_item.pair_ok   = m3_ff.pair_ok;
      push_item.overlap   = m3_ff.is_line ? (|seg_hit) : box_hit3_ff;
   end

   assign push = v3_ff;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNTW'(QUEUE_DEPTH))
      else $error("credit count above queue depth");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 push)
      else $error("accepted request did not reach the queue");

endmodule

/* hw/rtl/pcet_back.sv */
// Back part: clears the pair table after reset and applies queued requests to it.
`timescale 1ns / 1ps

module pcet_back import pcet_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  pcet_item_type head_item,
   output logic          pop,
   output logic          clearing,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output pcet_rsp_type  rsp_payload
);

   back_state_type      state_ff, state_in;
   logic [TABLE_AW-1:0] clr_ff, clr_in;
   pcet_item_type       item_ff, item_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pcet_rsp_type        rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [TABLE_AW-1:0]   wr_addr, rd_addr;
   logic [ENTRY_BITS-1:0] wr_data, rd_data, entry;
   logic                  out_free, load;

   pcet_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      item_in     = item_ff;
      pop         = 1'b0;
      load        = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = item_ff.pair_addr;
      wr_data     = '0;
      rd_addr     = item_ff.pair_addr;
      rsp_data_in = rsp_data_ff;
      entry       = rd_data;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + TABLE_AW'(1);
            if (clr_ff == TABLE_AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = head_item.pair_addr;
            if (head_valid) begin
               pop      = 1'b1;
               item_in  = head_item;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               load                  = 1'b1;
               state_in              = ST_IDLE;
               rsp_data_in.event_res = EV_NONE;
               rsp_data_in.overlap   = 1'b0;
               if (item_ff.pair_ok) begin
                  wr_en = 1'b1;
                  if (item_ff.command == CMD_QUIT) begin
                     wr_data = '0;
                     if (entry[PAIR_PRESENT_BIT]) begin
                        rsp_data_in.event_res = EV_EXIT;
                     end
                  end else begin
                     entry[PAIR_PRESENT_BIT] = 1'b1;
                     rsp_data_in.overlap     = item_ff.overlap;
                     if (item_ff.overlap) begin
                        if (entry[PAIR_COLLIDING_BIT]) begin
                           rsp_data_in.event_res = EV_STAY;
                        end else begin
                           rsp_data_in.event_res     = EV_ENTER;
                           entry[PAIR_COLLIDING_BIT] = 1'b1;
                        end
                     end else if (entry[PAIR_COLLIDING_BIT]) begin
                        rsp_data_in.event_res     = EV_EXIT;
                        entry[PAIR_COLLIDING_BIT] = 1'b0;
                     end
                     wr_data = entry;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign clearing    = (state_ff == ST_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE && head_valid)
      else $error("queue popped outside of the idle state");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("response presented during table clearing");

endmodule

/* hw/rtl/pair_collision_event_tracker_top.sv */
// Top level of the pair collision event tracker: geometry front, request queue, pair-table back.
// An accepted request passes the front stages (differences, products, determinant) into the queue;
// the back then reads the pair table entry, and then updates it and registers the response. The
// back takes a new request only once the last one is through this read-then-write turn on the
// pair table entry. Reset is synchronous; afterwards the table is swept to zero, during which
// req_stall stays high.
`timescale 1ns / 1ps

module pair_collision_event_tracker_top import pcet_pkg::*; #(
   parameter int ID_COUNT   = 64,
   parameter int COORD_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pcet_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pcet_rsp_type rsp_payload
);

   // Requests flow front -> queue -> back. The front reserves a queue slot
   // for each request it accepts, so its geometry pipeline never stalls, and
   // a stalled response only backs up into the queue.
   logic          push;
   pcet_item_type push_item;
   logic          pop;
   logic          head_valid;
   pcet_item_type head_item;
   logic          clearing;

   // The front checks the ids and works out the overlap: a centre/size test
   // for two boxes, or a segment test against each of the four box edges on
   // doubled coordinates with sign comparisons in place of a division.
   pcet_front #(
      .ID_COUNT   (ID_COUNT),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .clearing    (clearing),
      .pop         (pop),
      .push        (push),
      .push_item   (push_item)
   );

   pcet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // The back holds the table of tracked pairs and turns each request into
   // an enter, stay, exit or no event, updating the entry as it goes.
   pcet_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sim/testbench.sv */
// Self-checking testbench of the pair collision event tracker top level.
`timescale 1ns / 1ps

module testbench;
   import pcet_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   pcet_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   pcet_rsp_type rsp_payload;

   pair_collision_event_tracker_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   // Clock: 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Requests waiting to be driven, and responses predicted for accepted requests.
   pcet_req_type pending_reqs[$];
   pcet_rsp_type expected_events[$];

   // Private copy of the pair table: bit 0 present, bit 1 colliding.
   logic [1:0] pair_state[TABLE_DEPTH];

   int  failures = 0;
   bit  stimulus_done = 1'b0;
   int  sent_count = 0;

   // Set at the rising edge when the offered request was taken.
   bit  req_taken = 1'b0;

   // Receiver hold-off: once, a long stall that fills the block up.
   int  hold_cycles = 0;
   bit  hold_used = 1'b0;

   // Inclusive test of whether num lies between zero and det.
   function automatic bit between_zero(longint num, longint det);
      if (det > 0) begin
         return num >= 0 && num <= det;
      end
      return num <= 0 && num >= det;
   endfunction

   // Segment p1-p2 against segment p3-p4; a zero determinant never hits.
   function automatic bit segments_cross(longint x1, longint y1, longint x2, longint y2,
                                         longint x3, longint y3, longint x4, longint y4);
      longint det, na, nb;
      det = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
      na  = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
      nb  = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
      if (det == 0) begin
         return 1'b0;
      end
      return between_zero(na, det) && between_zero(nb, det);
   endfunction

   // Geometry on doubled coordinates, so halving a size never rounds.
   function automatic bit shapes_touch(pcet_req_type r);
      longint bx, by, bw, bh, oa, ob, oc, od, dx, dy;
      longint lx, rx, ty, byb;
      bx = r.box_x;   by = r.box_y;
      bw = r.box_w;   bh = r.box_h;
      oa = r.other_a; ob = r.other_b;
      oc = r.other_c; od = r.other_d;
      if (!r.other_is_line) begin
         dx = 2 * (bx - oa);
         dy = 2 * (by - ob);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         return dx <= bw + oc && dy <= bh + od;
      end
      lx = 2 * bx - bw;  rx = 2 * bx + bw;
      ty = 2 * by - bh;  byb = 2 * by + bh;
      return segments_cross(2*oa, 2*ob, 2*oc, 2*od, lx, byb, lx, ty) ||
             segments_cross(2*oa, 2*ob, 2*oc, 2*od, rx, byb, rx, ty) ||
             segments_cross(2*oa, 2*ob, 2*oc, 2*od, lx, ty, rx, ty) ||
             segments_cross(2*oa, 2*ob, 2*oc, 2*od, lx, byb, rx, byb);
   endfunction

   // Advances the pair table by one request and returns the event it reports.
   function automatic pcet_rsp_type track_pair(pcet_req_type r);
      pcet_rsp_type res;
      logic [TABLE_AW-1:0] addr;
      logic [1:0] e;
      res.event_res = EV_NONE;
      res.overlap   = 1'b0;
      if (r.left_id == r.right_id) begin
         return res;
      end
      addr = {r.left_id, r.right_id};
      e = pair_state[addr];
      if (r.command == CMD_QUIT) begin
         if (e[PAIR_PRESENT_BIT]) begin
            res.event_res = EV_EXIT;
            pair_state[addr] = 2'b00;
         end
         return res;
      end
      e[PAIR_PRESENT_BIT] = 1'b1;
      if (shapes_touch(r)) begin
         res.overlap = 1'b1;
         if (e[PAIR_COLLIDING_BIT]) begin
            res.event_res = EV_STAY;
         end else begin
            res.event_res = EV_ENTER;
            e[PAIR_COLLIDING_BIT] = 1'b1;
         end
      end else if (e[PAIR_COLLIDING_BIT]) begin
         res.event_res = EV_EXIT;
         e[PAIR_COLLIDING_BIT] = 1'b0;
      end
      pair_state[addr] = e;
      return res;
   endfunction

   function automatic pcet_req_type random_request(int id_span);
      pcet_req_type r;
      r = pcet_req_type'($bits(pcet_req_type)'({$urandom, $urandom, $urandom,
                                                 $urandom, $urandom, $urandom}));
      r.command  = ($urandom_range(0, 9) == 0) ? CMD_QUIT : CMD_CHECK;
      r.left_id  = 6'($urandom_range(0, id_span));
      r.right_id = 6'($urandom_range(0, id_span));
      // Keep most shapes near each other so that enter, stay and exit all occur.
      if ($urandom_range(0, 3) != 0) begin
         r.box_x   = $signed(16'($urandom_range(0, 400))) - 16'sd200;
         r.box_y   = $signed(16'($urandom_range(0, 400))) - 16'sd200;
         r.box_w   = 15'($urandom_range(0, 300));
         r.box_h   = 15'($urandom_range(0, 300));
         r.other_a = $signed(16'($urandom_range(0, 400))) - 16'sd200;
         r.other_b = $signed(16'($urandom_range(0, 400))) - 16'sd200;
         if (r.other_is_line) begin
            r.other_c = $signed(16'($urandom_range(0, 400))) - 16'sd200;
            r.other_d = $signed(16'($urandom_range(0, 400))) - 16'sd200;
         end else begin
            r.other_c = $signed(16'($urandom_range(0, 320))) - 16'sd20;
            r.other_d = $signed(16'($urandom_range(0, 320))) - 16'sd20;
         end
      end
      return r;
   endfunction

   function automatic pcet_req_type shaped(cmd_type cmd, int lid, int rid, bit line,
                                           int bx, int by, int bw, int bh,
                                           int oa, int ob, int oc, int od);
      pcet_req_type r;
      r.command = cmd; r.left_id = 6'(lid); r.right_id = 6'(rid); r.other_is_line = line;
      r.box_x = 16'(bx); r.box_y = 16'(by); r.box_w = 15'(bw); r.box_h = 15'(bh);
      r.other_a = 16'(oa); r.other_b = 16'(ob); r.other_c = 16'(oc); r.other_d = 16'(od);
      return r;
   endfunction

   // Fill the request queue: a directed part, then random traffic.
   initial begin
      pcet_req_type r;
      // Box against box: enter, stay on a touching edge (inclusive), exit, then no event.
      pending_reqs.push_back(shaped(CMD_CHECK, 1, 2, 0, 0, 0, 10, 10, 5, 0, 10, 10));
      pending_reqs.push_back(shaped(CMD_CHECK, 1, 2, 0, 0, 0, 10, 10, 10, 0, 10, 10));
      pending_reqs.push_back(shaped(CMD_CHECK, 1, 2, 0, 0, 0, 10, 10, 11, 0, 10, 10));
      pending_reqs.push_back(shaped(CMD_CHECK, 1, 2, 0, 0, 0, 10, 10, 30, 30, 10, 10));
      // Force quit of a present pair, then of an absent one.
      pending_reqs.push_back(shaped(CMD_QUIT, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(shaped(CMD_QUIT, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // The reverse order is a separate pair.
      pending_reqs.push_back(shaped(CMD_CHECK, 2, 1, 0, 0, 0, 4, 4, 0, 0, 4, 4));
      // Equal ids do nothing, for both commands.
      pending_reqs.push_back(shaped(CMD_CHECK, 7, 7, 0, 0, 0, 4, 4, 0, 0, 4, 4));
      pending_reqs.push_back(shaped(CMD_QUIT, 7, 7, 0, 0, 0, 4, 4, 0, 0, 4, 4));
      // Segment crossing a box, ending on an edge, and parallel on an edge.
      pending_reqs.push_back(shaped(CMD_CHECK, 3, 4, 1, 0, 0, 10, 10, -20, 0, 20, 0));
      pending_reqs.push_back(shaped(CMD_CHECK, 3, 5, 1, 0, 0, 10, 10, -20, 0, -5, 0));
      pending_reqs.push_back(shaped(CMD_CHECK, 3, 6, 1, 0, 0, 10, 10, -5, 5, 5, 5));
      // Segment of zero length, box of zero size, segment inside the box.
      pending_reqs.push_back(shaped(CMD_CHECK, 3, 8, 1, 0, 0, 10, 10, 5, 0, 5, 0));
      pending_reqs.push_back(shaped(CMD_CHECK, 3, 9, 1, 0, 0, 0, 0, -5, 0, 5, 0));
      pending_reqs.push_back(shaped(CMD_CHECK, 3, 10, 1, 0, 0, 10, 10, -1, 0, 1, 0));
      // Negative other box size.
      pending_reqs.push_back(shaped(CMD_CHECK, 4, 3, 0, 0, 0, 10, 10, 0, 0, -10, -10));
      pending_reqs.push_back(shaped(CMD_CHECK, 4, 5, 0, 0, 0, 10, 10, 0, 0, -11, 10));
      // Field extremes.
      pending_reqs.push_back(shaped(CMD_CHECK, 0, 63, 0, -32768, -32768, 32767, 32767,
                                    32767, 32767, 32767, 32767));
      pending_reqs.push_back(shaped(CMD_CHECK, 63, 0, 1, 32767, 32767, 32767, 32767,
                                    -32768, -32768, 32767, 32767));
      pending_reqs.push_back(shaped(CMD_CHECK, 63, 62, 1, -32768, 32767, 0, 32767,
                                    32767, -32768, -32768, 32767));
      pending_reqs.push_back(shaped(CMD_QUIT, 0, 63, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      // Random part: mostly a small id pool, so pairs repeat and pass through every state.
      for (int i = 0; i < 1250; i++) begin
         r = random_request(($urandom_range(0, 4) == 0) ? 63 : 5);
         pending_reqs.push_back(r);
      end
   end

   // Driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else if (req_valid && !req_taken) begin
         // A stalled request holds still.
      end else begin
         if (req_valid) begin
            sent_count++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
            stimulus_done <= 1'b1;
         end else begin
            req_payload <= pending_reqs.pop_front();
            req_valid   <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 30);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end
         end
      end
   end

   // Receiver stall pattern, with one long hold-off once traffic is flowing.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (!hold_used && sent_count > 300) begin
         hold_used   = 1'b1;
         hold_cycles = 200;
         rsp_stall <= 1'b1;
      end else if ((sent_count / 100) % 3 == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // Prediction on request acceptance, checking on response acceptance.
   always @(posedge clock) begin
      pcet_rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            expected_events.push_back(track_pair(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected response event=%0d overlap=%0d", $time,
                        rsp_payload.event_res, rsp_payload.overlap);
               failures++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_payload.event_res !== want.event_res) begin
                  $display("%0t: event_res expected %0d actual %0d", $time,
                           want.event_res, rsp_payload.event_res);
                  failures++;
               end
               if (rsp_payload.overlap !== want.overlap) begin
                  $display("%0t: overlap expected %0d actual %0d", $time,
                           want.overlap, rsp_payload.overlap);
                  failures++;
               end
            end
         end
      end
   end

   // Reset, clear the private table, then wait for the traffic to drain.
   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         pair_state[i] = 2'b00;
      end
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_events.size() == 0);
      repeat (50) @(posedge clock);
      if (failures == 0 && expected_events.size() == 0) begin
         $display("pair_collision_event_tracker_top test passed");
      end else begin
         $display("pair_collision_event_tracker_top test failed");
      end
      $finish;
   end

   // Timeout: room for the sweep, all requests and the stalls, several times over.
   initial begin
      #2000000;
      $display("pair_collision_event_tracker_top test failed");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/pcet_pkg.sv
hw/rtl/pcet_ram.sv
hw/rtl/pcet_queue.sv
hw/rtl/pcet_front.sv
hw/rtl/pcet_back.sv
hw/rtl/pair_collision_event_tracker_top.sv
sim/testbench.sv
